// ===== hdl/dynamic_priority_process_picker_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the task picker
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_PRIORITY_PROCESS_PICKER_TOP_DEFINES_SVH
`define DYNAMIC_PRIORITY_PROCESS_PICKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DPP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DPP_ASSERT(label, prop, msg)
`define DPP_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== hdl/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg
// Types, codes and sizes shared by the task picker.
// ----------------------------------------------------------------------------
package dpp_pkg;
  localparam int unsigned Slots   = 64;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned IdW     = 31;
  localparam int unsigned PrioW   = 7;
  localparam int unsigned CntW    = 32;

  typedef enum logic [2:0] {
    ACT_TICK = 3'd0, ACT_ADMIT = 3'd1, ACT_SETPRIO = 3'd2,
    ACT_SETSTATE = 3'd3, ACT_PICK = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    MODE_UNUSED = 3'd0, MODE_SLEEPING = 3'd1, MODE_RUNNABLE = 3'd2,
    MODE_ZOMBIE = 3'd3, MODE_RUNNING = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_WAIT, ST_VISIT, ST_DIV, ST_PICKRD, ST_PICKWAIT,
    ST_PICKWR, ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [SlotW-1:0] slot;
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] req_prio;
    logic [1:0]       new_state;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] chosen_slot;
    logic [IdW-1:0]   chosen_id;
    logic [PrioW-1:0] old_priority;
    logic [PrioW-1:0] dyn_priority;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;      // capture input word
    logic             rd;        // read entry at idx
    logic [SlotW-1:0] idx;
    logic             visit;     // apply action to read entry
    logic             div_start;
    logic             div_step;
    logic             pick_wr;   // commit the pick winner
    logic             clr_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             leave;     // set_state on a running slot
    logic             div_done;
    logic [SlotW-1:0] best;
    logic             have;
  } sts_t;
endpackage

// ===== hdl/dpp_if.sv =====
// ----------------------------------------------------------------------------
// dpp_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface dpp_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/dpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpp_ctrl
// Sequencer: walks the slot table one entry per step.
// ----------------------------------------------------------------------------
module dpp_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                action_i,
  input  logic [dpp_pkg::SlotW-1:0] slot_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  dpp_pkg::sts_t             sts_i,
  output dpp_pkg::cmd_t             cmd_o
);
  import dpp_pkg::*;

  state_e           state_q, state_d;
  logic [SlotW:0]   cnt_q, cnt_d;
  action_e          act_q, act_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      act_q   <= ACT_TICK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      act_q   <= act_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    act_d       = act_q;
    cmd_o       = '0;
    cmd_o.idx   = cnt_q[SlotW-1:0];
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.clr_out = 1'b1;
          act_d         = action_e'(action_i);
          // single-entry actions address the given slot, walks start at 0
          cnt_d         = (action_e'(action_i) inside {ACT_ADMIT, ACT_SETSTATE}) ?
                          {1'b0, slot_i} : '0;
          state_d       = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_WAIT;
      end
      ST_WAIT: state_d = ST_VISIT;
      ST_VISIT: begin
        cmd_o.visit = 1'b1;
        if (act_q == ACT_ADMIT || act_q == ACT_SETSTATE) begin
          if (act_q == ACT_SETSTATE && sts_i.leave) begin
            cmd_o.div_start = 1'b1;
            cnt_d           = '0;
            state_d         = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end else if (act_q == ACT_TICK || act_q == ACT_SETPRIO
                     || act_q == ACT_PICK) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == (SlotW+1)'(Slots - 1)) begin
            state_d = (act_q == ACT_PICK) ? ST_PICKRD : ST_OUT;
          end else begin
            state_d = ST_RD;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_OUT;
      end
      ST_PICKRD: begin
        cmd_o.idx = sts_i.best;
        cmd_o.rd  = sts_i.have;
        state_d   = sts_i.have ? ST_PICKWAIT : ST_OUT;
      end
      ST_PICKWAIT: begin
        cmd_o.idx = sts_i.best;
        state_d   = ST_PICKWR;
      end
      ST_PICKWR: begin
        cmd_o.idx     = sts_i.best;
        cmd_o.pick_wr = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/dpp_datapath.sv =====
// ----------------------------------------------------------------------------
// dpp_datapath
// Slot table memory, tick counter, best-slot tracker and niceness divider.
// ----------------------------------------------------------------------------
module dpp_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dpp_pkg::in_t  in_i,
  input  dpp_pkg::cmd_t cmd_i,
  output dpp_pkg::sts_t sts_o,
  output dpp_pkg::out_t out_o
);
  import dpp_pkg::*;

  // entry layout: id, prio, nice, dispatch, create, run, sleep
  localparam int unsigned EntW = IdW + PrioW + 4 + 4 * CntW;
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [3:0]       nice;
    logic [CntW-1:0]  disp;
    logic [CntW-1:0]  ctime;
    logic [CntW-1:0]  run;
    logic [CntW-1:0]  slp;
  } ent_t;

  ent_t              mem [Slots];
  logic [EntW-1:0]   rd_raw_q;
  ent_t              rd_q;
  mode_e             mode_q [Slots];
  mode_e             rmode_q;
  logic [SlotW-1:0]  ridx_q;
  in_t               in_q;
  logic [CntW-1:0]   now_q;
  out_t              out_q;
  logic              have_q;
  logic [SlotW-1:0]  best_q;
  logic [PrioW-1:0]  bdyn_q;
  logic [CntW-1:0]   bdisp_q, bctime_q;
  // divider
  logic [CntW:0]     den_q;
  logic [CntW+3:0]   num_q;
  logic [CntW:0]     rem_q;
  logic [3:0]        quo_q;
  logic [5:0]        dcnt_q;
  logic              div_zero_q;

  ent_t              wr_ent;
  logic              wr_en;
  logic [PrioW-1:0]  dyn;
  logic [PrioW-1:0]  prio_sat;
  logic              better;
  logic [CntW+1:0]   rem_sh;
  logic [CntW:0]     sum;

  assign rd_q = ent_t'(rd_raw_q);

  always_comb begin
    logic signed [PrioW+1:0] d;
    d = $signed({2'b00, rd_q.prio}) - $signed({{(PrioW-2){1'b0}}, rd_q.nice})
        + $signed((PrioW+2)'(5));
    if (d < 0) dyn = '0;
    else if (d > 100) dyn = PrioW'(100);
    else dyn = d[PrioW-1:0];
  end

  assign prio_sat = (in_q.req_prio > PrioW'(100)) ? PrioW'(100) : in_q.req_prio;
  assign better = !have_q || dyn < bdyn_q || (dyn == bdyn_q && rd_q.disp < bdisp_q)
                  || (dyn == bdyn_q && rd_q.disp == bdisp_q && rd_q.ctime < bctime_q);
  assign sum    = {1'b0, rd_q.run} + {1'b0, rd_q.slp};
  assign rem_sh = {rem_q, num_q[CntW+3]};

  always_comb begin
    wr_ent = rd_q;
    wr_en  = 1'b0;
    if (cmd_i.visit) begin
      case (action_e'(in_q.action))
        ACT_TICK: begin
          wr_en = (rmode_q == MODE_RUNNING) || (rmode_q == MODE_SLEEPING);
          if (rmode_q == MODE_RUNNING) wr_ent.run = rd_q.run + 1'b1;
          else wr_ent.slp = rd_q.slp + 1'b1;
        end
        ACT_ADMIT: begin
          wr_en        = 1'b1;
          wr_ent.id    = in_q.task_id;
          wr_ent.prio  = PrioW'(60);
          wr_ent.nice  = 4'd5;
          wr_ent.disp  = '0;
          wr_ent.ctime = now_q;
          wr_ent.run   = '0;
          wr_ent.slp   = '0;
        end
        ACT_SETPRIO: begin
          wr_en = (rmode_q != MODE_UNUSED) && (rd_q.id == in_q.task_id);
          wr_ent.prio = prio_sat;
          wr_ent.nice = 4'd5;
          wr_ent.run  = '0;
          wr_ent.slp  = '0;
        end
        default: ;
      endcase
    end else if (cmd_i.div_step && dcnt_q == 6'd0) begin
      wr_en       = 1'b1;
      wr_ent.nice = div_zero_q ? 4'd5 : quo_q;
      wr_ent.run  = '0;
      wr_ent.slp  = '0;
    end else if (cmd_i.pick_wr) begin
      wr_en       = 1'b1;
      wr_ent.disp = rd_q.disp + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_raw_q <= mem[cmd_i.idx];
      ridx_q   <= cmd_i.idx;
    end
    if (wr_en) mem[ridx_q] <= wr_ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) mode_q[i] <= MODE_UNUSED;
      now_q   <= '0;
      rmode_q <= MODE_UNUSED;
      have_q  <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      if (cmd_i.rd) rmode_q <= mode_q[cmd_i.idx];
      if (cmd_i.load) begin
        have_q <= 1'b0;
        if (action_e'(in_i.action) == ACT_TICK) now_q <= now_q + 1'b1;
      end
      if (cmd_i.visit) begin
        if (action_e'(in_q.action) == ACT_ADMIT) mode_q[ridx_q] <= MODE_RUNNABLE;
        if (action_e'(in_q.action) == ACT_SETSTATE)
          mode_q[ridx_q] <= mode_e'({1'b0, in_q.new_state});
        if (action_e'(in_q.action) == ACT_PICK && rmode_q == MODE_RUNNABLE && better)
          have_q <= 1'b1;
      end
      if (cmd_i.pick_wr) mode_q[ridx_q] <= MODE_RUNNING;
      if (cmd_i.div_start) dcnt_q <= 6'(CntW + 4);
      else if (cmd_i.div_step && dcnt_q != 6'd0) dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_i;
    if (cmd_i.clr_out) out_q <= '0;
    if (cmd_i.visit) begin
      if (action_e'(in_q.action) == ACT_PICK && rmode_q == MODE_RUNNABLE && better) begin
        best_q   <= ridx_q;
        bdyn_q   <= dyn;
        bdisp_q  <= rd_q.disp;
        bctime_q <= rd_q.ctime;
      end
      if (action_e'(in_q.action) == ACT_SETPRIO && wr_en) begin
        out_q.found        <= 1'b1;
        out_q.old_priority <= rd_q.prio;
      end
    end
    if (cmd_i.pick_wr) begin
      out_q.found        <= 1'b1;
      out_q.chosen_slot  <= ridx_q;
      out_q.chosen_id    <= rd_q.id;
      out_q.dyn_priority <= bdyn_q;
    end
    // restoring division of 10*sleep by run+sleep, one quotient bit a step
    if (cmd_i.div_start) begin
      den_q      <= sum;
      num_q      <= (CntW+4)'({rd_q.slp, 3'b000}) + (CntW+4)'({rd_q.slp, 1'b0});
      rem_q      <= '0;
      quo_q      <= '0;
      div_zero_q <= (sum == '0);
    end else if (cmd_i.div_step && dcnt_q != 6'd0) begin
      num_q <= {num_q[CntW+2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= (CntW+1)'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[CntW:0];
        quo_q <= {quo_q[2:0], 1'b0};
      end
    end
  end

  assign sts_o.leave    = (rmode_q == MODE_RUNNING);
  assign sts_o.div_done = (dcnt_q == 6'd0);
  assign sts_o.best     = best_q;
  assign sts_o.have     = have_q;
  assign out_o          = out_q;
endmodule

// ===== hdl/dynamic_priority_process_picker_top.sv =====
// ----------------------------------------------------------------------------
// dynamic_priority_process_picker_top
// Task slot table with dynamic priority pick.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | action, slot, task_id, req_prio, new_state
//  out_ch  | out | found, chosen_slot, chosen_id, old_priority, dyn_priority
//
// One word at a time. Admit and set_state read the given slot, apply the action
// and then present the result; set_state on a running slot also runs the divider.
// Tick, priority update and pick walk the table slot by slot through the
// registered memory read port; pick then commits the best runnable one, if any.
// A result held by the sink stalls the input. Reset clears slot modes and the
// time counter; no clearing pass.
`include "dynamic_priority_process_picker_top_defines.svh"
module dynamic_priority_process_picker_top (
  input  logic clk_i,
  input  logic rst_ni,
  dpp_if.sink   in_ch,
  dpp_if.source out_ch
);
  import dpp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  out_t res;

  dpp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid), .in_ready_o (in_ch.ready),
    .action_i   (in_ch.data.action),
    .slot_i     (in_ch.data.slot),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .sts_i (sts), .cmd_o (cmd)
  );

  dpp_datapath u_dp (
    .clk_i, .rst_ni,
    .in_i  (in_ch.data), .cmd_i (cmd), .sts_o (sts), .out_o (res)
  );

  assign out_ch.data = res;

  `DPP_ASSERT(a_no_overlap, !(in_ch.ready && out_ch.valid), "accept while result pending")
  `DPP_ASSERT(a_accept_result, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "ready after accept")
  `DPP_ASSERT(a_pick_found, (out_ch.valid && out_ch.data.dyn_priority != '0) |-> out_ch.data.found,
              "dyn priority without found")
  `DPP_ASSERT_RST(a_rst_idle, !rst_ni |-> !out_ch.valid, "result during reset")
endmodule
